FILE: src/hre_pkg.sv
// Shared types and constants of the homography reprojection error block.
package hre_pkg;

  localparam int CoordW    = 32;
  localparam int HW        = 48;
  localparam int NumRegs   = 8;
  localparam int CfgIdxW   = 4;
  localparam int QuotBits  = 36;
  localparam int SumW      = 82;
  localparam int NumW      = 98;
  localparam int CmpW      = 118;
  localparam int DistW     = 32;
  localparam int DiffW     = 40;
  localparam int SqW       = 64;
  localparam int SqrtSteps = 32;
  localparam int FrontLat  = 3;
  localparam int PostLat   = 3;

  localparam logic [CfgIdxW-1:0] IdxH00 = 4'd0;
  localparam logic [CfgIdxW-1:0] IdxH01 = 4'd1;
  localparam logic [CfgIdxW-1:0] IdxH02 = 4'd2;
  localparam logic [CfgIdxW-1:0] IdxH10 = 4'd3;
  localparam logic [CfgIdxW-1:0] IdxH11 = 4'd4;
  localparam logic [CfgIdxW-1:0] IdxH12 = 4'd5;
  localparam logic [CfgIdxW-1:0] IdxH20 = 4'd6;
  localparam logic [CfgIdxW-1:0] IdxH21 = 4'd7;

  localparam logic [HW-1:0] HOne = 48'h0001_0000_0000;

  typedef struct packed {
    logic signed [CoordW-1:0] src_x;
    logic signed [CoordW-1:0] src_y;
    logic signed [CoordW-1:0] dst_x;
    logic signed [CoordW-1:0] dst_y;
  } in_beat_t;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic             at_infinity;
    logic             saturated;
  } out_beat_t;

  typedef logic [NumRegs-1:0][HW-1:0] hmat_t;

  localparam hmat_t HReset = {{3{HW'(0)}}, HOne, {3{HW'(0)}}, HOne};

  typedef struct packed {
    logic [NumW-1:0]          rem_x;
    logic [NumW-1:0]          rem_y;
    logic [SumW-1:0]          dmag;
    logic [QuotBits:0]        q_x;
    logic [QuotBits:0]        q_y;
    logic                     neg_x;
    logic                     neg_y;
    logic                     inf;
    logic signed [CoordW-1:0] dst_x;
    logic signed [CoordW-1:0] dst_y;
  } div_t;

endpackage

FILE: src/hre_front.sv
// Front end: partial products, row sums and divider set-up over three stages.
module hre_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_vld,
  input  hre_pkg::in_beat_t in_beat,
  input  hre_pkg::hmat_t    hmat,
  output logic              out_vld,
  output hre_pkg::div_t     out_div
);
  import hre_pkg::*;

  logic signed [15:0] hhi [6];
  logic signed [32:0] hlo [6];
  logic signed [CoordW-1:0] src [6];

  logic signed [47:0] phi_r [6];
  logic signed [64:0] plo_r [6];
  logic signed [HW-1:0] h02_r, h12_r;
  logic signed [CoordW-1:0] dx1_r, dy1_r, dx2_r, dy2_r;
  logic signed [SumW-1:0] nx_r, ny_r, w_r;
  logic [FrontLat-1:0] vld_r;
  div_t div_r;

  localparam int Map [6] = '{0, 1, 3, 4, 6, 7};

  function automatic logic signed [SumW-1:0] term(logic signed [47:0] phi,
                                                   logic signed [64:0] plo);
    return (SumW'(phi) <<< 32) + SumW'(plo);
  endfunction

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      hhi[k] = $signed(hmat[Map[k]][HW-1:32]);
      hlo[k] = $signed({1'b0, hmat[Map[k]][31:0]});
      src[k] = (k % 2 == 0) ? in_beat.src_x : in_beat.src_y;
    end
  end

  logic signed [SumW-1:0] nx_nxt, ny_nxt, w_nxt;
  always_comb begin
    nx_nxt = term(phi_r[0], plo_r[0]) + term(phi_r[1], plo_r[1])
           + (SumW'(h02_r) <<< 16);
    ny_nxt = term(phi_r[2], plo_r[2]) + term(phi_r[3], plo_r[3])
           + (SumW'(h12_r) <<< 16);
    w_nxt  = term(phi_r[4], plo_r[4]) + term(phi_r[5], plo_r[5])
           + (SumW'(1) <<< 48);
  end

  logic [SumW-1:0] mx, my, mw;
  logic [NumW-1:0] nmx, nmy;
  logic sat_x, sat_y;
  div_t div_nxt;
  always_comb begin
    mx  = nx_r[SumW-1] ? SumW'(-nx_r) : SumW'(nx_r);
    my  = ny_r[SumW-1] ? SumW'(-ny_r) : SumW'(ny_r);
    mw  = w_r[SumW-1]  ? SumW'(-w_r)  : SumW'(w_r);
    nmx = NumW'(mx) << 16;
    nmy = NumW'(my) << 16;
    sat_x = CmpW'(nmx) >= (CmpW'(mw) << QuotBits);
    sat_y = CmpW'(nmy) >= (CmpW'(mw) << QuotBits);
    div_nxt.rem_x = sat_x ? '0 : nmx;
    div_nxt.rem_y = sat_y ? '0 : nmy;
    div_nxt.dmag  = mw;
    div_nxt.q_x   = sat_x ? (QuotBits+1)'(1) << QuotBits : '0;
    div_nxt.q_y   = sat_y ? (QuotBits+1)'(1) << QuotBits : '0;
    div_nxt.neg_x = nx_r[SumW-1] ^ w_r[SumW-1];
    div_nxt.neg_y = ny_r[SumW-1] ^ w_r[SumW-1];
    div_nxt.inf   = (w_r == '0);
    div_nxt.dst_x = dx2_r;
    div_nxt.dst_y = dy2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[FrontLat-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 6; k++) begin
        phi_r[k] <= hhi[k] * src[k];
        plo_r[k] <= hlo[k] * 65'(src[k]);
      end
      h02_r <= $signed(hmat[IdxH02]);
      h12_r <= $signed(hmat[IdxH12]);
      dx1_r <= in_beat.dst_x;
      dy1_r <= in_beat.dst_y;
      nx_r  <= nx_nxt;
      ny_r  <= ny_nxt;
      w_r   <= w_nxt;
      dx2_r <= dx1_r;
      dy2_r <= dy1_r;
      div_r <= div_nxt;
    end
  end

  assign out_vld = vld_r[FrontLat-1];
  assign out_div = div_r;

endmodule

FILE: src/hre_divider.sv
// Restoring divider for both projected coordinates, one quotient bit per stage.
module hre_divider (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_vld,
  input  hre_pkg::div_t in_div,
  output logic          out_vld,
  output hre_pkg::div_t out_div
);
  import hre_pkg::*;

  div_t st_r [QuotBits];
  logic [QuotBits-1:0] vld_r;

  for (genvar k = 0; k < QuotBits; k++) begin : g_stage
    localparam int Bit = QuotBits - 1 - k;
    div_t cur, st_nxt;
    logic [CmpW-1:0] dsh;
    logic ge_x, ge_y;

    if (k == 0) begin : g_first
      assign cur = in_div;
    end else begin : g_rest
      assign cur = st_r[k-1];
    end

    always_comb begin
      dsh    = CmpW'(cur.dmag) << Bit;
      ge_x   = CmpW'(cur.rem_x) >= dsh;
      ge_y   = CmpW'(cur.rem_y) >= dsh;
      st_nxt = cur;
      if (ge_x) begin
        st_nxt.rem_x    = cur.rem_x - dsh[NumW-1:0];
        st_nxt.q_x[Bit] = 1'b1;
      end
      if (ge_y) begin
        st_nxt.rem_y    = cur.rem_y - dsh[NumW-1:0];
        st_nxt.q_y[Bit] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[k] <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[QuotBits-2:0], in_vld};
    end
  end

  assign out_vld = vld_r[QuotBits-1];
  assign out_div = st_r[QuotBits-1];

endmodule

FILE: src/hre_distance.sv
// Back end: differences, squares, sum and a pipelined integer square root.
module hre_distance (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_vld,
  input  hre_pkg::div_t      in_div,
  output logic               out_vld,
  output hre_pkg::out_beat_t out_beat
);
  import hre_pkg::*;

  typedef struct packed {
    logic [SqW-1:0] n;
    logic [SqW-1:0] res;
    logic           inf;
    logic           big;
  } sq_t;

  logic signed [DiffW-1:0] qx, qy, dx, dy;
  logic [DiffW-1:0] mx, my;
  logic [DistW-1:0] mx_r, my_r;
  logic [SqW-1:0] a_r, b_r;
  logic inf1_r, inf2_r, big1_r, big2_r;
  logic [SqW:0] s;
  sq_t sq_r [SqrtSteps+1];
  logic [PostLat+SqrtSteps-1:0] vld_r;

  always_comb begin
    qx = in_div.neg_x ? -DiffW'(in_div.q_x) : DiffW'(in_div.q_x);
    qy = in_div.neg_y ? -DiffW'(in_div.q_y) : DiffW'(in_div.q_y);
    dx = qx - DiffW'(in_div.dst_x);
    dy = qy - DiffW'(in_div.dst_y);
    mx = dx[DiffW-1] ? DiffW'(-dx) : DiffW'(dx);
    my = dy[DiffW-1] ? DiffW'(-dy) : DiffW'(dy);
    s  = {1'b0, a_r} + {1'b0, b_r};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mx_r   <= mx[DistW-1:0];
      my_r   <= my[DistW-1:0];
      big1_r <= (mx[DiffW-1:DistW] != '0) || (my[DiffW-1:DistW] != '0);
      inf1_r <= in_div.inf;
      a_r    <= SqW'(mx_r) * SqW'(mx_r);
      b_r    <= SqW'(my_r) * SqW'(my_r);
      big2_r <= big1_r;
      inf2_r <= inf1_r;
      sq_r[0].n   <= s[SqW-1:0];
      sq_r[0].res <= '0;
      sq_r[0].inf <= inf2_r;
      sq_r[0].big <= big2_r | s[SqW];
    end
  end

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    localparam logic [SqW-1:0] BitV = SqW'(1) << (SqW - 2 - 2 * k);
    sq_t st_nxt;
    logic [SqW:0] t;

    always_comb begin
      t      = {1'b0, sq_r[k].res} + {1'b0, BitV};
      st_nxt = sq_r[k];
      if ({1'b0, sq_r[k].n} >= t) begin
        st_nxt.n   = sq_r[k].n - t[SqW-1:0];
        st_nxt.res = (sq_r[k].res >> 1) + BitV;
      end else begin
        st_nxt.res = sq_r[k].res >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_r[k+1] <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PostLat+SqrtSteps-2:0], in_vld};
    end
  end

  always_comb begin
    out_beat.distance    = sq_r[SqrtSteps].res[DistW-1:0];
    out_beat.at_infinity = 1'b0;
    out_beat.saturated   = 1'b0;
    if (sq_r[SqrtSteps].inf) begin
      out_beat.distance    = '0;
      out_beat.at_infinity = 1'b1;
    end else if (sq_r[SqrtSteps].big) begin
      out_beat.distance  = '1;
      out_beat.saturated = 1'b1;
    end
  end

  assign out_vld = vld_r[PostLat+SqrtSteps-1];

endmodule

FILE: src/homography_reprojection_error.sv
// Top level of the homography reprojection error pipeline.
// Each input beat carries a source point and a measured destination point,
// all signed Q15.16. The source point is mapped through the homography held
// in eight 48-bit Q15.32 registers (bottom-right entry fixed at one) and the
// Euclidean distance to the destination is returned as unsigned Q16.16.
// A zero homogeneous denominator sets at_infinity with a zero distance; a
// distance beyond range returns all ones with saturated set.
// Registers are written via cfg_we, cfg_index and cfg_wdata; the user must
// do so only while the pipeline is empty, which the block does not enforce.
// Indexes beyond the eighth register are ignored. One beat is accepted per
// cycle unless the receiver stalls; each result passes through three front
// stages for products and row sums, 36 divider stages with one quotient bit
// each, three for differences, squares and their sum, 32 square root
// stages and the output register. Reset clears all valid bits and loads
// the identity matrix. When the receiver stalls with a result waiting, the
// whole pipeline holds and in_ready falls; nothing is lost or repeated.
module homography_reprojection_error (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  hre_pkg::in_beat_t             in_beat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output hre_pkg::out_beat_t            out_beat,
  input  logic                          cfg_we,
  input  logic [hre_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [hre_pkg::HW-1:0]        cfg_wdata
);
  import hre_pkg::*;

  hmat_t hmat_r;
  logic adv;
  logic f_vld, d_vld, b_vld;
  div_t f_div, d_div;
  out_beat_t b_beat, out_r;
  logic out_valid_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hmat_r <= HReset;
    end else if (cfg_we && (cfg_index < CfgIdxW'(NumRegs))) begin
      hmat_r[cfg_index[2:0]] <= cfg_wdata;
    end
  end

  hre_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (in_valid),
    .in_beat (in_beat),
    .hmat    (hmat_r),
    .out_vld (f_vld),
    .out_div (f_div)
  );

  hre_divider u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (f_vld),
    .in_div  (f_div),
    .out_vld (d_vld),
    .out_div (d_div)
  );

  hre_distance u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (d_vld),
    .in_div   (d_div),
    .out_vld  (b_vld),
    .out_beat (b_beat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= b_beat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

  a_inf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.at_infinity |-> out_beat.distance == '0 && !out_beat.saturated)
    else $error("at_infinity result with non-zero distance or saturation");

  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.saturated |-> out_beat.distance == '1)
    else $error("saturated result without maximum distance");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_beat))
    else $error("stalled result changed");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline stalled");

endmodule
